FILE: hw/rtl/gshare_branch_predictor_with_agreement_unit_defines.svh
// ---------------------------------------------------------------------------
// Gshare predictor assertion macros
// Shared concurrent assertion forms for the predictor checker.
// ---------------------------------------------------------------------------
`ifndef GSHARE_BRANCH_PREDICTOR_WITH_AGREEMENT_UNIT_DEFINES_SVH
`define GSHARE_BRANCH_PREDICTOR_WITH_AGREEMENT_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define GBPA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gbpa assertion failed");

// next-cycle implication, disabled while reset is low
`define GBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gbpa assertion failed");

`endif

FILE: hw/rtl/gbpa_pkg.sv
// ---------------------------------------------------------------------------
// gbpa_pkg
// Types, counter constants and saturating helpers for the gshare predictor.
// ---------------------------------------------------------------------------
package gbpa_pkg;

    localparam int CNT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX    = 2'd3;
    localparam logic [CNT_W-1:0] CNT_MIN    = 2'd0;
    localparam logic [CNT_W-1:0] CNT_THRESH = 2'd2;
    localparam logic [CNT_W-1:0] DIR_RESET  = 2'd1;
    localparam logic [CNT_W-1:0] AGR_RESET  = 2'd3;

    localparam logic FUNC_PREDICT = 1'b0;
    localparam logic FUNC_UPDATE  = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0] dir;
        logic [CNT_W-1:0] agr;
    } entry_t;

    typedef struct packed {
        logic func;
        logic taken;
        logic guessed;
    } op_t;

    localparam entry_t ENTRY_RESET = '{dir: DIR_RESET, agr: AGR_RESET};

    function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? CNT_MAX : c + 2'd1;
    endfunction

    function automatic logic [CNT_W-1:0] sat_down(input logic [CNT_W-1:0] c);
        return (c == CNT_MIN) ? CNT_MIN : c - 2'd1;
    endfunction

endpackage

FILE: hw/rtl/gbpa_ram.sv
// ---------------------------------------------------------------------------
// gbpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module gbpa_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/gbpa_core.sv
// ---------------------------------------------------------------------------
// gbpa_core
// Prediction and counter update for one table entry.
// ---------------------------------------------------------------------------
module gbpa_core (
    input  gbpa_pkg::entry_t rd_entry,
    input  gbpa_pkg::op_t    op,
    output logic             pred,
    output gbpa_pkg::entry_t wr_entry
);

    logic dir_taken;
    logic agr_keep;

    assign dir_taken = (rd_entry.dir >= gbpa_pkg::CNT_THRESH);
    assign agr_keep  = (rd_entry.agr >= gbpa_pkg::CNT_THRESH);

    // weak agreement flips the direction bit
    assign pred = agr_keep ? dir_taken : ~dir_taken;

    always_comb begin
        wr_entry.agr = (op.taken == op.guessed) ? gbpa_pkg::sat_up(rd_entry.agr)
                                                : gbpa_pkg::sat_down(rd_entry.agr);
        wr_entry.dir = op.taken ? gbpa_pkg::sat_up(rd_entry.dir)
                                : gbpa_pkg::sat_down(rd_entry.dir);
    end

endmodule

FILE: hw/rtl/gbpa_outq.sv
// ---------------------------------------------------------------------------
// gbpa_outq
// Two-entry result buffer: output register plus skid slot.
// ---------------------------------------------------------------------------
module gbpa_outq (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  logic push_data,
    input  logic m_ready,
    output logic m_valid,
    output logic m_data,
    output logic full
);

    logic out_valid_reg, out_valid_next;
    logic out_data_reg,  out_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg,  skid_data_next;
    logic out_free;

    assign out_free = ~out_valid_reg | m_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = push;
                skid_data_next  = push_data;
            end else begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;
    assign full    = skid_valid_reg;

endmodule

FILE: hw/rtl/gshare_branch_predictor_with_agreement_unit.sv
// ---------------------------------------------------------------------------
// gshare_branch_predictor_with_agreement_unit
// Gshare direction predictor with per-entry agreement counters.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_func = 0 asks for a prediction at s_pc, s_func = 1
//   trains the entry with s_resolved_taken and s_predicted_taken and shifts
//   the outcome into the global history. Table index is
//   s_pc[HISTORY_BITS-1:0] ^ history.
//   Result channel m_*: one m_predict_taken per prediction request; updates
//   return nothing.
//   Each transfer reads the entry from the counter RAM in the transfer cycle
//   and writes it back (update) or turns it into a result (predict) in the
//   next. A new item is not taken until the single read-modify-write pass
//   over the RAM is done. A prediction is pushed into the result buffer and
//   registered there before it shows on m_valid.
//   After reset the RAM is swept to its initial counters, one entry a cycle,
//   with s_ready low until every entry is written. History resets to zero.
//   A stalled receiver is absorbed by a two-deep result buffer; besides the
//   execute step of each item, s_ready also stays low while both slots hold
//   results.
// ---------------------------------------------------------------------------
module gshare_branch_predictor_with_agreement_unit #(
    parameter int HISTORY_BITS = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_pc,
    input  logic        s_resolved_taken,
    input  logic        s_predicted_taken,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_predict_taken
);

    localparam int TABLE_DEPTH = 2 ** HISTORY_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [HISTORY_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    logic [HISTORY_BITS-1:0] hist_reg, hist_next;
    logic [HISTORY_BITS-1:0] idx_reg, idx_next;
    gbpa_pkg::op_t           op_reg, op_next;

    logic [HISTORY_BITS-1:0] rd_idx;
    logic                    accept;
    logic                    q_full;
    logic                    ram_we;
    logic [HISTORY_BITS-1:0] ram_waddr;
    gbpa_pkg::entry_t        ram_wdata;
    gbpa_pkg::entry_t        rd_entry;
    gbpa_pkg::entry_t        upd_entry;
    logic                    pred;
    logic                    push;

    assign s_ready = (state_reg == S_IDLE) & ~q_full;
    assign accept  = s_valid & s_ready;
    assign rd_idx  = s_pc[HISTORY_BITS-1:0] ^ hist_reg;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        hist_next    = hist_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == {HISTORY_BITS{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    idx_next   = rd_idx;
                    op_next    = '{func: s_func, taken: s_resolved_taken,
                                   guessed: s_predicted_taken};
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (op_reg.func == gbpa_pkg::FUNC_UPDATE) begin
                    hist_next = {hist_reg[HISTORY_BITS-2:0], op_reg.taken};
                end
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            hist_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            hist_reg    <= hist_next;
        end
        idx_reg <= idx_next;
        op_reg  <= op_next;
    end

    assign ram_we    = (state_reg == S_CLEAR) |
                       ((state_reg == S_EXEC) & (op_reg.func == gbpa_pkg::FUNC_UPDATE));
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : idx_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? gbpa_pkg::ENTRY_RESET : upd_entry;

    gbpa_ram #(
        .WIDTH ($bits(gbpa_pkg::entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx),
        .rdata (rd_entry)
    );

    gbpa_core u_core (
        .rd_entry (rd_entry),
        .op       (op_reg),
        .pred     (pred),
        .wr_entry (upd_entry)
    );

    assign push = (state_reg == S_EXEC) & (op_reg.func == gbpa_pkg::FUNC_PREDICT);

    gbpa_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (pred),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_predict_taken),
        .full      (q_full)
    );

endmodule

FILE: hw/rtl/gbpa_checker.sv
// ---------------------------------------------------------------------------
// gbpa_checker
// Port-level checks for the gshare predictor, bound to the top level.
// ---------------------------------------------------------------------------
`include "gshare_branch_predictor_with_agreement_unit_defines.svh"

module gbpa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic        m_valid,
    input logic        m_ready
);

    // result held until taken
    `GBPA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // one RAM pass per transfer: never two transfers in a row
    `GBPA_ASSERT_NEXT(a_no_b2b, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a fresh result only comes from a prediction transfer, via the execute state and the output register
    `GBPA_ASSERT_NOW(a_rose_src, aclk, aresetn, $rose(m_valid),
        $past(s_valid && s_ready && !s_func, 2))

    // an update transfer produces no result
    `GBPA_ASSERT_NEXT(a_upd_silent, aclk, aresetn,
        s_valid && s_ready && s_func && !m_valid, ##1 !m_valid)

endmodule

bind gshare_branch_predictor_with_agreement_unit gbpa_checker u_gbpa_checker (.*);
